FILE: rtl/srtf_scheduler_defines.svh
// ---------------------------------------------------------------------------
// srtf_scheduler assertion macros
// Concurrent assertion helpers used by the scheduler controller. Each check is
// clocked by clk_i and switched off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SRTF_SCHEDULER_DEFINES_SVH
`define SRTF_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define SRTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SRTF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SRTF_ASSERT(lbl, prop, msg)
`define SRTF_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/srtf_pkg.sv
// ---------------------------------------------------------------------------
// srtf_pkg
// Types, constants and helpers shared by the SRTF scheduler modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srtf_pkg;

  localparam int unsigned NUM_CELLS = 16;
  localparam int unsigned IDX_W     = $clog2(NUM_CELLS);
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned SUM_W     = 20;

  localparam logic [CNT_W-1:0] PC_RESET = CNT_W'(NUM_CELLS);

  // Command codes of an input beat.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Register index as decoded from paddr[2].
  localparam logic REG_PROCESS_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_EXEC,
    ST_STAT
  } srtf_state_e;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  entry_index;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_time;
  } srtf_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  running_index;
    logic              idle;
    logic              started;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] response_time;
    logic [SUM_W-1:0]  total_waiting;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_response;
    logic              all_done;
  } srtf_res_t;

  // Best-so-far token that walks down the cell chain during a scan.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [IDX_W-1:0]  pick;
    logic [TIME_W-1:0] best;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic              responded;
    logic [TIME_W-1:0] response;
  } srtf_tok_t;

  // Write broadcast from the controller to all cells.
  typedef struct packed {
    logic              load;
    logic              dec;
    logic              set_resp;
    logic [IDX_W-1:0]  index;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] response;
  } srtf_wr_t;

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0]  acc,
                                               input logic [TIME_W-1:0] val);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(val);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

FILE: rtl/srtf_scheduler.sv
// ---------------------------------------------------------------------------
// srtf_scheduler
// Shortest-remaining-time-first scheduler over a table of process entries.
// ---------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. A load beat passes the
// load and statistics states before its result strobe; a tick beat passes the
// scan, where the best-so-far token walks the row of entry cells one cell per
// clock, then the token latch and the update and statistics states. busy drops
// in the cycle of the result strobe, so the next beat can be taken at the same
// edge as the result. The strobe lasts one cycle and cannot be held off, so
// sample res_o whenever res_valid_o is high. process_count is written through
// the APB port at byte address 0; the user writes it only while the block is
// not busy, which the block itself does not enforce.
`timescale 1ns / 1ps

module srtf_scheduler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  srtf_pkg::srtf_item_t item_i,
  output logic                 res_valid_o,
  output srtf_pkg::srtf_res_t  res_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [srtf_pkg::CNT_W-1:0]      pc_q;
  logic [srtf_pkg::TIME_W-1:0]     tick;
  srtf_pkg::srtf_wr_t              wr;
  srtf_pkg::srtf_tok_t             chain [srtf_pkg::NUM_CELLS+1];
  logic [srtf_pkg::NUM_CELLS-1:0]  has_work;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= srtf_pkg::PC_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == srtf_pkg::REG_PROCESS_COUNT) begin
      pc_q <= pwdata[srtf_pkg::CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == srtf_pkg::REG_PROCESS_COUNT) ?
                  {{(32-srtf_pkg::CNT_W){1'b0}}, pc_q} : '0;

  srtf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .item_i       (item_i),
    .tok_launch_o (chain[0]),
    .tok_last_i   (chain[srtf_pkg::NUM_CELLS]),
    .has_work_i   (has_work),
    .wr_o         (wr),
    .tick_o       (tick),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

  for (genvar i = 0; i < srtf_pkg::NUM_CELLS; i++) begin : g_cell
    srtf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (srtf_pkg::IDX_W'(i)),
      .count_i    (pc_q),
      .tick_i     (tick),
      .wr_i       (wr),
      .tok_i      (chain[i]),
      .tok_o      (chain[i+1]),
      .has_work_o (has_work[i])
    );
  end

endmodule

FILE: rtl/srtf_cell.sv
// ---------------------------------------------------------------------------
// srtf_cell
// One process entry of the scheduler table plus one stage of the scan chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srtf_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [srtf_pkg::IDX_W-1:0]   idx_i,
  input  logic [srtf_pkg::CNT_W-1:0]   count_i,
  input  logic [srtf_pkg::TIME_W-1:0]  tick_i,
  input  srtf_pkg::srtf_wr_t           wr_i,
  input  srtf_pkg::srtf_tok_t          tok_i,
  output srtf_pkg::srtf_tok_t          tok_o,
  output logic                         has_work_o
);

  logic [srtf_pkg::TIME_W-1:0] arr_q, bur_q, rsp_q, rem_q;
  logic                        resp_flag_q;
  srtf_pkg::srtf_tok_t         tok_q, tok_d;
  logic                        hit, enabled, eligible, take;

  assign hit      = (wr_i.index == idx_i);
  assign enabled  = ({1'b0, idx_i} < count_i);
  assign eligible = enabled && (arr_q <= tick_i) && (rem_q != '0);
  // Ties go to the higher index, so an equal remaining time still takes over.
  assign take     = tok_i.valid && eligible && (!tok_i.found || rem_q <= tok_i.best);

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.found     = 1'b1;
      tok_d.pick      = idx_i;
      tok_d.best      = rem_q;
      tok_d.arrival   = arr_q;
      tok_d.burst     = bur_q;
      tok_d.responded = resp_flag_q;
      tok_d.response  = rsp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      resp_flag_q <= 1'b0;
      tok_q       <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_i.load && hit) begin
        rem_q       <= wr_i.burst;
        resp_flag_q <= 1'b0;
      end else if (wr_i.dec && hit) begin
        rem_q <= rem_q - srtf_pkg::TIME_W'(1);
        if (wr_i.set_resp) begin
          resp_flag_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.load && hit) begin
      arr_q <= wr_i.arrival;
      bur_q <= wr_i.burst;
    end
    if (wr_i.dec && wr_i.set_resp && hit) begin
      rsp_q <= wr_i.response;
    end
  end

  assign tok_o      = tok_q;
  assign has_work_o = enabled && (rem_q != '0);

endmodule

FILE: rtl/srtf_ctrl.sv
// ---------------------------------------------------------------------------
// srtf_ctrl
// Sequencer of the scheduler: broadcasts loads, launches scans, applies the
// chosen update and builds the result beat with time and running totals.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "srtf_scheduler_defines.svh"

module srtf_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  srtf_pkg::srtf_item_t                item_i,
  output srtf_pkg::srtf_tok_t                 tok_launch_o,
  input  srtf_pkg::srtf_tok_t                 tok_last_i,
  input  logic [srtf_pkg::NUM_CELLS-1:0]      has_work_i,
  output srtf_pkg::srtf_wr_t                  wr_o,
  output logic [srtf_pkg::TIME_W-1:0]         tick_o,
  output logic                                res_valid_o,
  output srtf_pkg::srtf_res_t                 res_o
);

  srtf_pkg::srtf_state_e       state_q, state_d;
  srtf_pkg::srtf_item_t        item_q;
  srtf_pkg::srtf_tok_t         tok_q;
  srtf_pkg::srtf_res_t         res_q, out_q;
  srtf_pkg::srtf_res_t         exec_res, stat_res;
  logic                        out_valid_q;
  logic [srtf_pkg::TIME_W-1:0] tick_q, tick_inc;
  logic                        cur_valid_q;
  logic [srtf_pkg::IDX_W-1:0]  cur_idx_q;
  logic [srtf_pkg::SUM_W-1:0]  sum_w_q, sum_t_q, sum_r_q;
  logic [srtf_pkg::SUM_W-1:0]  sum_w_nx, sum_t_nx, sum_r_nx;
  logic                        started, set_resp, fin_now;
  logic [srtf_pkg::TIME_W-1:0] resp_new, wt_now;

  assign tick_inc = (tick_q == {srtf_pkg::TIME_W{1'b1}}) ? tick_q
                                                         : tick_q + srtf_pkg::TIME_W'(1);
  assign started  = !cur_valid_q || (cur_idx_q != tok_q.pick);
  assign set_resp = started && !tok_q.responded;
  assign resp_new = set_resp ? (tick_q - tok_q.arrival) : tok_q.response;
  assign fin_now  = (tok_q.best == srtf_pkg::TIME_W'(1));

  // Saturated time can leave turnaround below the burst; waiting then reads zero.
  assign wt_now   = (res_q.finished && res_q.turnaround_time >= tok_q.burst) ?
                    (res_q.turnaround_time - tok_q.burst) : '0;
  assign sum_w_nx = res_q.finished ? srtf_pkg::sat_sum(sum_w_q, wt_now) : sum_w_q;
  assign sum_t_nx = res_q.finished ? srtf_pkg::sat_sum(sum_t_q, res_q.turnaround_time)
                                   : sum_t_q;
  assign sum_r_nx = res_q.finished ? srtf_pkg::sat_sum(sum_r_q, res_q.response_time)
                                   : sum_r_q;

  always_comb begin
    exec_res = '0;
    if (tok_q.found) begin
      exec_res.running_index = tok_q.pick;
      exec_res.started       = started;
      exec_res.finished      = fin_now;
      if (fin_now) begin
        exec_res.finish_time     = tick_inc;
        exec_res.turnaround_time = tick_inc - tok_q.arrival;
        exec_res.response_time   = resp_new;
      end
    end else begin
      exec_res.idle = 1'b1;
    end
  end

  always_comb begin
    stat_res                  = res_q;
    stat_res.waiting_time     = wt_now;
    stat_res.total_waiting    = sum_w_nx;
    stat_res.total_turnaround = sum_t_nx;
    stat_res.total_response   = sum_r_nx;
    stat_res.all_done         = ~|has_work_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srtf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    wr_o         = '0;
    tok_launch_o = '0;
    busy_o       = (state_q != srtf_pkg::ST_IDLE);
    case (state_q)
      srtf_pkg::ST_IDLE: begin
        if (start_i) begin
          if (item_i.cmd == srtf_pkg::CMD_TICK) begin
            tok_launch_o.valid = 1'b1;
            state_d            = srtf_pkg::ST_SCAN;
          end else begin
            state_d = srtf_pkg::ST_LOAD;
          end
        end
      end
      srtf_pkg::ST_LOAD: begin
        wr_o.load    = 1'b1;
        wr_o.index   = item_q.entry_index;
        wr_o.arrival = item_q.arrival_time;
        wr_o.burst   = item_q.burst_time;
        state_d      = srtf_pkg::ST_STAT;
      end
      srtf_pkg::ST_SCAN: begin
        if (tok_last_i.valid) begin
          state_d = srtf_pkg::ST_EXEC;
        end
      end
      srtf_pkg::ST_EXEC: begin
        if (tok_q.found) begin
          wr_o.dec      = 1'b1;
          wr_o.set_resp = set_resp;
          wr_o.index    = tok_q.pick;
          wr_o.response = resp_new;
        end
        state_d = srtf_pkg::ST_STAT;
      end
      srtf_pkg::ST_STAT: begin
        state_d = srtf_pkg::ST_IDLE;
      end
      default: begin
        state_d = srtf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q      <= '0;
      tok_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      tick_q      <= '0;
      cur_valid_q <= 1'b0;
      cur_idx_q   <= '0;
      sum_w_q     <= '0;
      sum_t_q     <= '0;
      sum_r_q     <= '0;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        srtf_pkg::ST_IDLE: begin
          if (start_i) begin
            item_q <= item_i;
            res_q  <= '0;
          end
        end
        srtf_pkg::ST_LOAD: begin
          if (cur_valid_q && cur_idx_q == item_q.entry_index) begin
            cur_valid_q <= 1'b0;
          end
        end
        srtf_pkg::ST_SCAN: begin
          if (tok_last_i.valid) begin
            tok_q <= tok_last_i;
          end
        end
        srtf_pkg::ST_EXEC: begin
          tick_q <= tick_inc;
          res_q  <= exec_res;
          if (tok_q.found) begin
            cur_idx_q   <= tok_q.pick;
            cur_valid_q <= !fin_now;
          end
        end
        srtf_pkg::ST_STAT: begin
          sum_w_q     <= sum_w_nx;
          sum_t_q     <= sum_t_nx;
          sum_r_q     <= sum_r_nx;
          out_q       <= stat_res;
          out_valid_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign tick_o      = tick_q;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  `SRTF_ASSERT(a_tok_only_in_scan, tok_last_i.valid |-> state_q == srtf_pkg::ST_SCAN, "scan token left the chain outside a scan")
  `SRTF_ASSERT(a_stat_gives_beat, state_q == srtf_pkg::ST_STAT |=> res_valid_o, "result beat missing after the statistics step")
  `SRTF_ASSERT(a_finish_drops_current, res_valid_o && res_o.finished |-> !cur_valid_q, "finished entry is still marked current")
  `SRTF_ASSERT(a_idle_beat_clean, res_valid_o && res_o.idle |-> !res_o.finished && !res_o.started, "idle tick reports a served entry")
  `SRTF_NEVER(a_one_write_kind, wr_o.load && wr_o.dec, "load and decrement broadcast together")

endmodule
